>>> rtl/wlct_pkg.sv
// ----------------------------------------------------------------------------
// wlct_pkg
// Types, codes and defaults shared by the link congestion tracker modules.
// ----------------------------------------------------------------------------
package wlct_pkg;

   localparam int MAX_NODES_DEF     = 16;
   localparam int REPORT_DEPTH_DEF  = 64;
   localparam int CLOSURE_DEPTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF   = 8;

   localparam logic [5:0]  THRESHOLD_RST  = 6'd3;
   localparam logic [31:0] TTL_RST        = 32'd100;
   localparam logic [4:0]  NODE_COUNT_RST = 5'd16;

   localparam logic [1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_TTL        = 2'd1;
   localparam logic [1:0] CSR_NODE_COUNT = 2'd2;

   localparam logic [2:0] OP_REPORT = 3'd0;
   localparam logic [2:0] OP_PURGE  = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_POP    = 3'd3;
   localparam logic [2:0] OP_LOAD   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_QFULL    = 2'd2;
   localparam logic [1:0] ST_NO_REC   = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  src_node;
      logic [3:0]  dst_node;
      logic [31:0] now_time;
      logic        is_adjacent;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        newly_closed;
      logic        portal_closed;
      logic        link_closed;
      logic [3:0]  record_src;
      logic [3:0]  record_dst;
      logic [31:0] record_time;
      logic [6:0]  expired_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PURGE_RD,
      S_PURGE_CNT,
      S_PURGE_UPD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic purge_rd;
      logic purge_cnt;
      logic purge_upd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_purge;
      logic head_expired;
   } stat_type;

endpackage

>>> rtl/wlct_ctrl.sv
// ----------------------------------------------------------------------------
// wlct_ctrl
// Sequencer: accepts a word, runs one execute step and, for a purge, the
// purge walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wlct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  wlct_pkg::stat_type  stat,
   output wlct_pkg::cmd_type   cmd
);

   wlct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wlct_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlct_pkg::S_IDLE: begin
            if (req_valid) state_in = wlct_pkg::S_EXEC;
         end
         wlct_pkg::S_EXEC: begin
            if (stat.is_purge) state_in = wlct_pkg::S_PURGE_RD;
            else               state_in = wlct_pkg::S_DONE;
         end
         wlct_pkg::S_PURGE_RD: begin
            state_in = wlct_pkg::S_PURGE_CNT;
         end
         wlct_pkg::S_PURGE_CNT: begin
            state_in = wlct_pkg::S_PURGE_UPD;
         end
         wlct_pkg::S_PURGE_UPD: begin
            if (stat.head_expired) state_in = wlct_pkg::S_PURGE_RD;
            else                   state_in = wlct_pkg::S_DONE;
         end
         wlct_pkg::S_DONE: begin
            if (out_free) state_in = wlct_pkg::S_IDLE;
         end
         default: state_in = wlct_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wlct_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         wlct_pkg::S_EXEC:      cmd.exec = 1'b1;
         wlct_pkg::S_PURGE_RD:  cmd.purge_rd = 1'b1;
         wlct_pkg::S_PURGE_CNT: cmd.purge_cnt = 1'b1;
         wlct_pkg::S_PURGE_UPD: cmd.purge_upd = 1'b1;
         wlct_pkg::S_DONE:      cmd.finish = out_free;
         default: ;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one command");
   a_cap_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec) else $error("capture not followed by execute");
   a_rd_upd: assert property (@(posedge clock) disable iff (reset)
      cmd.purge_rd |=> cmd.purge_cnt) else $error("purge read without count read");

endmodule

>>> rtl/wlct_dp.sv
// ----------------------------------------------------------------------------
// wlct_dp
// Datapath: count and link memories, report FIFO, closure stack, result.
// ----------------------------------------------------------------------------
module wlct_dp #(
   parameter int REPORT_DEPTH  = wlct_pkg::REPORT_DEPTH_DEF,
   parameter int CLOSURE_DEPTH = wlct_pkg::CLOSURE_DEPTH_DEF,
   parameter int COUNT_WIDTH   = wlct_pkg::COUNT_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  wlct_pkg::req_type  req,
   input  wlct_pkg::cmd_type  cmd,
   output wlct_pkg::stat_type stat,
   output wlct_pkg::rsp_type  result,
   input  logic [5:0]         threshold,
   input  logic [31:0]        time_to_live,
   input  logic [4:0]         node_count
);

   localparam int MAX_NODES = wlct_pkg::MAX_NODES_DEF;
   localparam int NW    = $clog2(MAX_NODES);
   localparam int PAIRS = MAX_NODES * MAX_NODES;
   localparam int PW    = 2 * NW;
   localparam int QW    = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
   localparam int QFW   = $clog2(REPORT_DEPTH + 1);
   localparam int TW    = QFW + 1;
   localparam int SW    = (CLOSURE_DEPTH > 1) ? $clog2(CLOSURE_DEPTH) : 1;
   localparam int SFW   = $clog2(CLOSURE_DEPTH + 1);
   localparam int CW    = COUNT_WIDTH;
   localparam int XW    = (COUNT_WIDTH > 7) ? COUNT_WIDTH + 1 : 8;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic [3:0]  src;
      logic [3:0]  dst;
      logic [31:0] tm;
   } rec_type;

   // pair state: valid bits stand for the reset value
   logic signed [CW-1:0] cnt_mem [PAIRS];
   logic [PAIRS-1:0]     cnt_vld_ff;
   logic [PAIRS-1:0]     link_ff;
   rec_type              q_mem [REPORT_DEPTH];
   rec_type              s_mem [CLOSURE_DEPTH];

   wlct_pkg::req_type    req_ff;
   logic [QW-1:0]        head_ff;
   logic [QFW-1:0]       fill_ff;
   logic [SFW-1:0]       sfill_ff;
   logic [6:0]           exp_ff;
   logic signed [CW-1:0] cnt_rd_ff;
   rec_type              qh_ff;
   rec_type              s_rd_ff;
   wlct_pkg::rsp_type    result_ff;

   logic                 ok;
   logic [PW-1:0]        idx, ridx, req_idx, cnt_raddr;
   logic signed [CW-1:0] cnt_inc, cnt_dec;
   logic signed [XW-1:0] thr_s, thr_p1, cur_x, inc_x, dec_x;
   logic                 closes;

   assign ok = ({1'b0, req_ff.src_node} < node_count) &&
               ({28'd0, req_ff.src_node} < 32'(MAX_NODES)) &&
               ({1'b0, req_ff.dst_node} < node_count) &&
               ({28'd0, req_ff.dst_node} < 32'(MAX_NODES));
   assign idx  = {req_ff.src_node[NW-1:0], req_ff.dst_node[NW-1:0]};
   assign ridx = {qh_ff.src[NW-1:0], qh_ff.dst[NW-1:0]};
   assign req_idx   = {req.src_node[NW-1:0], req.dst_node[NW-1:0]};
   assign cnt_raddr = cmd.capture ? req_idx : ridx;
   assign thr_s  = $signed({{(XW-7){1'b0}}, 1'b0, threshold});
   assign thr_p1 = thr_s + XW'(1);
   assign cnt_inc = (cnt_rd_ff < CMAX) ? cnt_rd_ff + CW'(1) : cnt_rd_ff;
   assign cnt_dec = (cnt_rd_ff > CMIN) ? cnt_rd_ff - CW'(1) : cnt_rd_ff;
   assign cur_x  = XW'(cnt_rd_ff);
   assign inc_x  = XW'(cnt_inc);
   assign dec_x  = XW'(cnt_dec);
   assign closes = (inc_x == thr_p1);

   logic head_exp;
   assign head_exp = (fill_ff != '0) && ((req_ff.now_time - qh_ff.tm) > time_to_live);
   assign stat.is_purge     = (req_ff.opcode == wlct_pkg::OP_PURGE);
   assign stat.head_expired = head_exp;
   assign result = result_ff;

   logic [TW-1:0] tail_sum;
   logic [QW-1:0] tail, head_nxt;
   assign tail_sum = TW'(head_ff) + TW'(fill_ff);
   assign tail = (tail_sum >= TW'(REPORT_DEPTH)) ?
                 QW'(tail_sum - TW'(REPORT_DEPTH)) : QW'(tail_sum);
   assign head_nxt = (head_ff == QW'(REPORT_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req;
         s_rd_ff <= s_mem[SW'(sfill_ff - 1'b1)];
      end
      if (cmd.purge_rd) begin
         qh_ff     <= q_mem[head_ff];
      end
      if (cmd.capture || cmd.purge_cnt) begin
         cnt_rd_ff <= cnt_vld_ff[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
      end
      if (cmd.exec) begin
         if (req_ff.opcode == wlct_pkg::OP_REPORT && ok &&
             fill_ff < QFW'(REPORT_DEPTH)) begin
            q_mem[tail] <= {req_ff.src_node, req_ff.dst_node, req_ff.now_time};
            cnt_mem[idx] <= cnt_inc;
            if (closes && sfill_ff < SFW'(CLOSURE_DEPTH))
               s_mem[SW'(sfill_ff)] <=
                  {req_ff.src_node, req_ff.dst_node, req_ff.now_time};
         end else if (req_ff.opcode == wlct_pkg::OP_LOAD && ok) begin
            cnt_mem[idx] <= req_ff.is_adjacent ? '0 : '1;
         end
      end
      if (cmd.purge_upd && head_exp) cnt_mem[ridx] <= cnt_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         link_ff    <= '0;
         head_ff    <= '0;
         fill_ff    <= '0;
         sfill_ff   <= '0;
         exp_ff     <= '0;
      end else begin
         if (cmd.exec) begin
            exp_ff <= '0;
            if (req_ff.opcode == wlct_pkg::OP_REPORT && ok &&
                fill_ff < QFW'(REPORT_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
               cnt_vld_ff[idx] <= 1'b1;
               if (closes) begin
                  link_ff[idx] <= 1'b1;
                  link_ff[{req_ff.dst_node[NW-1:0], req_ff.src_node[NW-1:0]}] <= 1'b1;
                  if (sfill_ff < SFW'(CLOSURE_DEPTH)) sfill_ff <= sfill_ff + 1'b1;
               end
            end else if (req_ff.opcode == wlct_pkg::OP_LOAD && ok) begin
               cnt_vld_ff[idx] <= 1'b1;
            end else if (req_ff.opcode == wlct_pkg::OP_POP && sfill_ff != '0) begin
               sfill_ff <= sfill_ff - 1'b1;
            end
         end
         if (cmd.purge_upd && head_exp) begin
            head_ff <= head_nxt;
            fill_ff <= fill_ff - 1'b1;
            exp_ff  <= exp_ff + 1'b1;
            cnt_vld_ff[ridx] <= 1'b1;
            if (!(dec_x > thr_s)) begin
               link_ff[ridx] <= 1'b0;
               link_ff[{qh_ff.dst[NW-1:0], qh_ff.src[NW-1:0]}] <= 1'b0;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         result_ff <= '0;
         unique case (req_ff.opcode)
            wlct_pkg::OP_REPORT: begin
               if (!ok) result_ff.status <= wlct_pkg::ST_RANGE;
               else if (fill_ff >= QFW'(REPORT_DEPTH))
                  result_ff.status <= wlct_pkg::ST_QFULL;
               else result_ff.newly_closed <= closes;
            end
            wlct_pkg::OP_QUERY: begin
               if (!ok) result_ff.status <= wlct_pkg::ST_RANGE;
               else begin
                  result_ff.portal_closed <= (cur_x > thr_s);
                  result_ff.link_closed   <= link_ff[idx];
               end
            end
            wlct_pkg::OP_POP: begin
               if (sfill_ff == '0) result_ff.status <= wlct_pkg::ST_NO_REC;
               else begin
                  result_ff.record_src  <= s_rd_ff.src;
                  result_ff.record_dst  <= s_rd_ff.dst;
                  result_ff.record_time <= s_rd_ff.tm;
               end
            end
            wlct_pkg::OP_LOAD: begin
               if (!ok) result_ff.status <= wlct_pkg::ST_RANGE;
            end
            default: ;
         endcase
      end
      if (cmd.purge_upd && !head_exp) result_ff.expired_count <= exp_ff;
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFW'(REPORT_DEPTH)) else $error("queue overfill");
   a_sfill: assert property (@(posedge clock) disable iff (reset)
      sfill_ff <= SFW'(CLOSURE_DEPTH)) else $error("stack overfill");
   a_exp: assert property (@(posedge clock) disable iff (reset)
      (cmd.purge_upd && head_exp) |=> (exp_ff == $past(exp_ff) + 1'b1))
      else $error("expired count lost");

endmodule

>>> rtl/windowed_link_congestion_tracker.sv
// ----------------------------------------------------------------------------
// windowed_link_congestion_tracker
// Failure-report counting per node pair with link closure and aging.
// ----------------------------------------------------------------------------
// req_ carries one command word (report, purge, query, pop, load adjacency);
// rsp_ returns exactly one result word for each command, in order.
// csr_ writes threshold, time_to_live and node_count; write only when idle.
// After the execute step, a purge walks the queue, spending a queue read, a
// count read and an update step per entry.
// One command is processed at a time; req_ready is high only when the
// sequencer is idle.
// Reset clears counts (via per-pair valid bits), link marks, queue and stack
// pointers at once; no clearing pass is needed.
// A stalled rsp_ready holds the result; the next word is accepted once
// the result has moved into the output register.
// ----------------------------------------------------------------------------
module windowed_link_congestion_tracker #(
   parameter int REPORT_DEPTH  = wlct_pkg::REPORT_DEPTH_DEF,
   parameter int CLOSURE_DEPTH = wlct_pkg::CLOSURE_DEPTH_DEF,
   parameter int COUNT_WIDTH   = wlct_pkg::COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wlct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wlct_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic [5:0]  thr_ff;
   logic [31:0] ttl_ff;
   logic [4:0]  nc_ff;
   logic        rsp_valid_ff;
   wlct_pkg::rsp_type rsp_ff, dp_result;
   wlct_pkg::cmd_type  cmd;
   wlct_pkg::stat_type stat;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= wlct_pkg::THRESHOLD_RST;
         ttl_ff <= wlct_pkg::TTL_RST;
         nc_ff  <= wlct_pkg::NODE_COUNT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            wlct_pkg::CSR_THRESHOLD:  thr_ff <= csr_data[5:0];
            wlct_pkg::CSR_TTL:        ttl_ff <= csr_data;
            wlct_pkg::CSR_NODE_COUNT: nc_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= dp_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wlct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   wlct_dp #(
      .REPORT_DEPTH  (REPORT_DEPTH),
      .CLOSURE_DEPTH (CLOSURE_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req          (req_data),
      .cmd          (cmd),
      .stat         (stat),
      .result       (dp_result),
      .threshold    (thr_ff),
      .time_to_live (ttl_ff),
      .node_count   (nc_ff)
   );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Link congestion tracker check: directed and random command words are sent
// through the request channel; each result word is compared field by field
// with a prediction kept in step with every accepted command.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES    = 16;
   localparam int QDEPTH   = 64;
   localparam int SDEPTH   = 16;
   localparam int CNT_HI   = 127;
   localparam int CNT_LO   = -128;
   localparam int WDOG_MAX = 20000;

   typedef struct {
      logic [3:0]  src;
      logic [3:0]  dst;
      logic [31:0] stamp;
   } entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   wlct_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   wlct_pkg::rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor state
   int          pair_cnt [NODES*NODES];
   bit          link_mark[NODES*NODES];
   entry_type   rpt_fifo[$];
   entry_type   closure_lifo[$];
   logic [5:0]  thr;
   logic [31:0] ttl;
   logic [4:0]  nodes_used;

   wlct_pkg::rsp_type expected_words[$];
   int      errors = 0;
   int      wdog = 0;
   bit      rx_hold = 1'b0;
   bit      no_idle = 1'b0;
   logic [31:0] clk_now = 0;

   windowed_link_congestion_tracker dut (.*);

   always #1 clock = ~clock;

   function automatic bit node_ok(logic [3:0] n);
      return {1'b0, n} < nodes_used;
   endfunction

   function automatic void mark_link(logic [3:0] a, logic [3:0] b, bit v);
      link_mark[a*NODES+b] = v;
      link_mark[b*NODES+a] = v;
   endfunction

   function automatic wlct_pkg::rsp_type predict_tracker(wlct_pkg::req_type c);
      wlct_pkg::rsp_type r;
      bit        ok;
      int        ix;
      int        ri;
      entry_type e;
      r  = '0;
      ok = node_ok(c.src_node) && node_ok(c.dst_node);
      ix = c.src_node * NODES + c.dst_node;
      case (c.opcode)
         wlct_pkg::OP_REPORT: begin
            if (!ok) r.status = wlct_pkg::ST_RANGE;
            else if (rpt_fifo.size() >= QDEPTH) r.status = wlct_pkg::ST_QFULL;
            else begin
               e.src = c.src_node; e.dst = c.dst_node; e.stamp = c.now_time;
               rpt_fifo = {rpt_fifo, e};
               if (pair_cnt[ix] < CNT_HI) pair_cnt[ix]++;
               if (pair_cnt[ix] == int'(thr) + 1) begin
                  mark_link(c.src_node, c.dst_node, 1'b1);
                  r.newly_closed = 1'b1;
                  if (closure_lifo.size() < SDEPTH) closure_lifo = {closure_lifo, e};
               end
            end
         end
         wlct_pkg::OP_PURGE: begin
            while (rpt_fifo.size() > 0) begin
               e = rpt_fifo[0];
               if (32'(c.now_time - e.stamp) <= ttl) break;
               void'(rpt_fifo.pop_front());
               r.expired_count++;
               ri = e.src * NODES + e.dst;
               if (pair_cnt[ri] > CNT_LO) pair_cnt[ri]--;
               if (!(pair_cnt[ri] > int'(thr))) mark_link(e.src, e.dst, 1'b0);
            end
         end
         wlct_pkg::OP_QUERY: begin
            if (!ok) r.status = wlct_pkg::ST_RANGE;
            else begin
               r.portal_closed = pair_cnt[ix] > int'(thr);
               r.link_closed   = link_mark[ix];
            end
         end
         wlct_pkg::OP_POP: begin
            if (closure_lifo.size() == 0) r.status = wlct_pkg::ST_NO_REC;
            else begin
               e = closure_lifo[$];
               closure_lifo.delete(closure_lifo.size() - 1);
               r.record_src = e.src; r.record_dst = e.dst; r.record_time = e.stamp;
            end
         end
         wlct_pkg::OP_LOAD: begin
            if (!ok) r.status = wlct_pkg::ST_RANGE;
            else pair_cnt[ix] = c.is_adjacent ? 0 : -1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      wlct_pkg::rsp_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t unexpected word %h", $time, rsp_data);
         end else begin
            x = expected_words.pop_front();
            if (rsp_data.status !== x.status || rsp_data.newly_closed !== x.newly_closed ||
                rsp_data.portal_closed !== x.portal_closed ||
                rsp_data.link_closed !== x.link_closed ||
                rsp_data.record_src !== x.record_src || rsp_data.record_dst !== x.record_dst ||
                rsp_data.record_time !== x.record_time ||
                rsp_data.expired_count !== x.expired_count) begin
               errors++;
               $display("%0t mismatch expected %p actual %p", $time, x, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_word(wlct_pkg::req_type c);
      if (!no_idle && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < 36) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words = {expected_words, predict_tracker(c)};
      @(negedge clock);
   endtask

   task automatic send_op(logic [2:0] op, logic [3:0] s, logic [3:0] d,
                          logic [31:0] t, logic a);
      wlct_pkg::req_type c;
      c.opcode = op; c.src_node = s; c.dst_node = d; c.now_time = t; c.is_adjacent = a;
      send_word(c);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] v);
      drain();
      csr_write <= 1'b1; csr_index <= idx; csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         wlct_pkg::CSR_THRESHOLD:  thr = v[5:0];
         wlct_pkg::CSR_TTL:        ttl = v;
         wlct_pkg::CSR_NODE_COUNT: nodes_used = v[4:0];
         default: ;
      endcase
   endtask

   task automatic test_directed;
      send_op(wlct_pkg::OP_POP, 0, 0, 0, 0);
      send_op(wlct_pkg::OP_QUERY, 15, 15, 0, 0);
      send_op(wlct_pkg::OP_LOAD, 15, 0, 0, 0);
      send_op(3'd5, 15, 15, '1, 1);
      send_op(3'd7, 0, 0, 0, 1);
      for (int i = 0; i < 4; i++) send_op(wlct_pkg::OP_REPORT, 1, 2, 32'(10 + i), 0);
      send_op(wlct_pkg::OP_QUERY, 2, 1, 0, 0);
      send_op(wlct_pkg::OP_QUERY, 1, 2, 0, 0);
      send_op(wlct_pkg::OP_PURGE, 0, 0, 200, 0);
      send_op(wlct_pkg::OP_QUERY, 1, 2, 0, 0);
      send_op(wlct_pkg::OP_POP, 0, 0, 0, 0);
      send_op(wlct_pkg::OP_LOAD, 3, 4, 0, 1);
      send_op(wlct_pkg::OP_REPORT, 15, 15, 32'hFFFF_FFFF, 0);
      send_op(wlct_pkg::OP_PURGE, 0, 0, 32'd50, 0);
      write_csr(wlct_pkg::CSR_NODE_COUNT, 5'd1);
      send_op(wlct_pkg::OP_REPORT, 1, 0, 5, 0);
      send_op(wlct_pkg::OP_QUERY, 0, 1, 0, 0);
      send_op(wlct_pkg::OP_REPORT, 0, 0, 5, 0);
      write_csr(wlct_pkg::CSR_NODE_COUNT, 5'd16);
   endtask

   task automatic test_saturation;
      write_csr(wlct_pkg::CSR_THRESHOLD, 6'd63);
      write_csr(wlct_pkg::CSR_TTL, '1);
      for (int i = 0; i < 64; i++) send_op(wlct_pkg::OP_REPORT, 5, 6, clk_now, 0);
      send_op(wlct_pkg::OP_REPORT, 5, 6, clk_now, 0);
      send_op(wlct_pkg::OP_QUERY, 5, 6, 0, 0);
      write_csr(wlct_pkg::CSR_TTL, 32'd0);
      send_op(wlct_pkg::OP_PURGE, 0, 0, clk_now + 1, 0);
      send_op(wlct_pkg::OP_LOAD, 7, 7, 0, 0);
      for (int i = 0; i < 130; i++) begin
         send_op(wlct_pkg::OP_LOAD, 7, 7, 0, i < 129 ? 0 : 0);
         send_op(wlct_pkg::OP_REPORT, 7, 7, clk_now, 0);
         send_op(wlct_pkg::OP_PURGE, 0, 0, clk_now + 1, 0);
      end
      send_op(wlct_pkg::OP_QUERY, 7, 7, 0, 0);
   endtask

   task automatic test_stack_full;
      write_csr(wlct_pkg::CSR_THRESHOLD, 6'd0);
      write_csr(wlct_pkg::CSR_TTL, 32'd1000);
      for (int i = 0; i < 20; i++)
         send_op(wlct_pkg::OP_REPORT, 4'(i % 16), 4'((i + 3) % 16), clk_now, 0);
      for (int i = 0; i < 18; i++) send_op(wlct_pkg::OP_POP, 0, 0, 0, 0);
      send_op(wlct_pkg::OP_PURGE, 0, 0, clk_now + 2000, 0);
   endtask

   task automatic test_backpressure;
      drain();
      rx_hold = 1'b1;
      fork
         begin repeat (300) @(negedge clock); rx_hold = 1'b0; end
         for (int i = 0; i < 20; i++) send_op(wlct_pkg::OP_QUERY, 4'(i % 16), 3, 0, 0);
      join
      drain();
   endtask

   task automatic random_phase(int n, logic [5:0] t, logic [31:0] l, logic [4:0] nc);
      int k;
      logic [2:0] op;
      write_csr(wlct_pkg::CSR_THRESHOLD, t);
      write_csr(wlct_pkg::CSR_TTL, l);
      write_csr(wlct_pkg::CSR_NODE_COUNT, nc);
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         clk_now += $urandom_range(40);
         if (k < 45) op = wlct_pkg::OP_REPORT;
         else if (k < 60) op = wlct_pkg::OP_PURGE;
         else if (k < 75) op = wlct_pkg::OP_QUERY;
         else if (k < 87) op = wlct_pkg::OP_POP;
         else if (k < 97) op = wlct_pkg::OP_LOAD;
         else op = 3'($urandom_range(7, 5));
         send_op(op, (k % 5 == 0) ? 4'($urandom) : 4'($urandom_range(3)),
                 (k % 7 == 0) ? 4'($urandom) : 4'($urandom_range(3)),
                 (op == wlct_pkg::OP_REPORT || op == wlct_pkg::OP_PURGE) ?
                    clk_now : $urandom, 1'($urandom));
      end
   endtask

   task automatic test_random;
      random_phase(200, 6'd3, 32'd100, 5'd16);
      random_phase(200, 6'd0, 32'd20, 5'd16);
      no_idle = 1'b1;
      random_phase(150, 6'd5, 32'd500, 5'd4);
      no_idle = 1'b0;
      random_phase(150, 6'd63, 32'hFFFF_FFFF, 5'd2);
      random_phase(200, 6'd1, 32'd60, 5'd8);
      clk_now += 32'hFFFF_F000;
      random_phase(100, 6'd2, 32'd80, 5'd16);
   endtask

   initial begin
      thr = wlct_pkg::THRESHOLD_RST;
      ttl = wlct_pkg::TTL_RST;
      nodes_used = wlct_pkg::NODE_COUNT_RST;
      foreach (pair_cnt[i]) begin pair_cnt[i] = 0; link_mark[i] = 1'b0; end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_saturation();
      test_stack_full();
      test_random();
      drain();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/wlct_pkg.sv
rtl/wlct_ctrl.sv
rtl/wlct_dp.sv
rtl/windowed_link_congestion_tracker.sv
tb/sv/tb.sv
